/* src/lsk_pkg.sv */
// lsk_pkg: shared constants for the two-field landau site kernel
// default number format, pipeline depths and register index codes
// no dependencies
package lsk_pkg;

  // default Q8.24 number format
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 24;

  // register stages inside one field unit and in the whole pipeline
  localparam int FLD_STAGES  = 10;
  localparam int PIPE_STAGES = 13;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_QUAD_ONE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUARTIC_ONE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAD_ONE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUAD_TWO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_QUARTIC_TWO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRAD_TWO    = 3'd5;

endpackage

/* src/lsk_mul.sv */
// lsk_mul: two-stage fixed point multiplier, exact product then
// round to nearest (ties up) and saturate; uses lsk_pkg
module lsk_mul import lsk_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic [1:0]                   en,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  output logic signed [DATA_WIDTH-1:0] y
);

  localparam int PW = 2 * DATA_WIDTH;
  localparam int SW = PW - FRAC_BITS + 1;
  localparam logic signed [PW:0] RND = (PW+1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic signed [PW-1:0]         prod_r;
  logic signed [PW:0]           rsum;
  logic signed [SW-1:0]         shft;
  logic [SW-DATA_WIDTH:0]       hi_bits;
  logic signed [DATA_WIDTH-1:0] y_nxt;
  logic signed [DATA_WIDTH-1:0] y_r;

  // exact product
  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_r <= a * b;
    end
  end

  // round, drop fraction bits, saturate
  always_comb begin
    rsum    = {prod_r[PW-1], prod_r} + RND;
    shft    = rsum[PW:FRAC_BITS];
    hi_bits = shft[SW-1:DATA_WIDTH-1];
    if ((&hi_bits) || !(|hi_bits)) begin
      y_nxt = shft[DATA_WIDTH-1:0];
    end else begin
      y_nxt = shft[SW-1] ? SMIN : SMAX;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      y_r <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

/* src/lsk_addsub.sv */
// lsk_addsub: registered saturating add or subtract
// uses lsk_pkg for the default width
module lsk_addsub import lsk_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter bit SUB        = 1'b0
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  output logic signed [DATA_WIDTH-1:0] y
);

  localparam logic signed [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic signed [DATA_WIDTH:0]   ext_a;
  logic signed [DATA_WIDTH:0]   ext_b;
  logic signed [DATA_WIDTH:0]   sum;
  logic signed [DATA_WIDTH-1:0] y_nxt;
  logic signed [DATA_WIDTH-1:0] y_r;

  // one extra bit, then clamp on overflow
  always_comb begin
    ext_a = {a[DATA_WIDTH-1], a};
    ext_b = {b[DATA_WIDTH-1], b};
    sum   = SUB ? (ext_a - ext_b) : (ext_a + ext_b);
    if (sum[DATA_WIDTH] == sum[DATA_WIDTH-1]) begin
      y_nxt = sum[DATA_WIDTH-1:0];
    end else begin
      y_nxt = sum[DATA_WIDTH] ? SMIN : SMAX;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_r <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

/* src/lsk_delay.sv */
// lsk_delay: shift line that carries a word alongside the pipeline,
// each tap loads under its own stage enable; uses lsk_pkg
module lsk_delay import lsk_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int DEPTH      = 1
) (
  input  logic                         clk,
  input  logic [DEPTH-1:0]             en,
  input  logic signed [DATA_WIDTH-1:0] d,
  output logic signed [DATA_WIDTH-1:0] q
);

  logic signed [DATA_WIDTH-1:0] tap_r [DEPTH];

  // one tap per stage
  for (genvar i = 0; i < DEPTH; i++) begin : g_tap
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[i]) begin
          tap_r[i] <= d;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[i]) begin
          tap_r[i] <= tap_r[i-1];
        end
      end
    end
  end

  assign q = tap_r[DEPTH-1];

endmodule

/* src/lsk_field.sv */
// lsk_field: ten-stage datapath for one phi-fourth field: energy part,
// chemical potential, isotropic pressure and gradient stress products
// uses lsk_pkg, lsk_mul, lsk_addsub, lsk_delay
module lsk_field import lsk_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic [FLD_STAGES:1]          en,
  input  logic signed [DATA_WIDTH-1:0] quad_coef,
  input  logic signed [DATA_WIDTH-1:0] quartic_coef,
  input  logic signed [DATA_WIDTH-1:0] grad_penalty,
  input  logic signed [DATA_WIDTH-1:0] value,
  input  logic signed [DATA_WIDTH-1:0] grad_x,
  input  logic signed [DATA_WIDTH-1:0] grad_y,
  input  logic signed [DATA_WIDTH-1:0] grad_z,
  input  logic signed [DATA_WIDTH-1:0] laplacian,
  output logic signed [DATA_WIDTH-1:0] energy,
  output logic signed [DATA_WIDTH-1:0] mu,
  output logic signed [DATA_WIDTH-1:0] pres,
  output logic signed [DATA_WIDTH-1:0] sxx,
  output logic signed [DATA_WIDTH-1:0] sxy,
  output logic signed [DATA_WIDTH-1:0] sxz,
  output logic signed [DATA_WIDTH-1:0] syy,
  output logic signed [DATA_WIDTH-1:0] syz,
  output logic signed [DATA_WIDTH-1:0] szz
);

  localparam int W = DATA_WIDTH;
  localparam logic signed [W-1:0] HALF   = W'(1) << (FRAC_BITS - 1);
  localparam logic signed [W-1:0] QUART  = W'(1) << (FRAC_BITS - 2);
  localparam logic signed [W-1:0] THREEQ = W'(3) << (FRAC_BITS - 2);

  logic signed [W-1:0] p2, gx2, gy2, gz2, ha, hk, qb, tb, av, klap, vlap;
  logic signed [W-1:0] kgx, kgy, kgz;
  logic signed [W-1:0] v_d2, gx_d2, gy_d2, gz_d2;
  logic signed [W-1:0] p4, qbp2, p2v, hap2, kvlap;
  logic signed [W-1:0] s_xx, s_xy, s_xz, s_yy, s_yz, s_zz;
  logic signed [W-1:0] g01, gz2_d3, gg;
  logic signed [W-1:0] ha_d4, hk_d5, tb_d5, p2_d5, av_d7, klap_d8;
  logic signed [W-1:0] t_s5, gg_d5, p4_d5, p2v_d5, hap2_d7, kvlap_d8;
  logic signed [W-1:0] tp2, tbp4, bp2v, hkgg;
  logic signed [W-1:0] fe_s8, m1_s8, pa_s8, hkgg_d9;
  logic signed [W-1:0] mu_s9, pb_s9;

  // stages 1-2: first level of products
  lsk_mul #(W, FRAC_BITS) u_p2   (.clk, .en(en[2:1]), .a(value),        .b(value),     .y(p2));
  lsk_mul #(W, FRAC_BITS) u_gx2  (.clk, .en(en[2:1]), .a(grad_x),       .b(grad_x),    .y(gx2));
  lsk_mul #(W, FRAC_BITS) u_gy2  (.clk, .en(en[2:1]), .a(grad_y),       .b(grad_y),    .y(gy2));
  lsk_mul #(W, FRAC_BITS) u_gz2  (.clk, .en(en[2:1]), .a(grad_z),       .b(grad_z),    .y(gz2));
  lsk_mul #(W, FRAC_BITS) u_ha   (.clk, .en(en[2:1]), .a(HALF),         .b(quad_coef), .y(ha));
  lsk_mul #(W, FRAC_BITS) u_hk   (.clk, .en(en[2:1]), .a(HALF),         .b(grad_penalty), .y(hk));
  lsk_mul #(W, FRAC_BITS) u_qb   (.clk, .en(en[2:1]), .a(QUART),        .b(quartic_coef), .y(qb));
  lsk_mul #(W, FRAC_BITS) u_tb   (.clk, .en(en[2:1]), .a(THREEQ),       .b(quartic_coef), .y(tb));
  lsk_mul #(W, FRAC_BITS) u_av   (.clk, .en(en[2:1]), .a(quad_coef),    .b(value),     .y(av));
  lsk_mul #(W, FRAC_BITS) u_klap (.clk, .en(en[2:1]), .a(grad_penalty), .b(laplacian), .y(klap));
  lsk_mul #(W, FRAC_BITS) u_vlap (.clk, .en(en[2:1]), .a(value),        .b(laplacian), .y(vlap));
  lsk_mul #(W, FRAC_BITS) u_kgx  (.clk, .en(en[2:1]), .a(grad_penalty), .b(grad_x),    .y(kgx));
  lsk_mul #(W, FRAC_BITS) u_kgy  (.clk, .en(en[2:1]), .a(grad_penalty), .b(grad_y),    .y(kgy));
  lsk_mul #(W, FRAC_BITS) u_kgz  (.clk, .en(en[2:1]), .a(grad_penalty), .b(grad_z),    .y(kgz));

  lsk_delay #(W, 2) u_v_d2  (.clk, .en(en[2:1]), .d(value),  .q(v_d2));
  lsk_delay #(W, 2) u_gx_d2 (.clk, .en(en[2:1]), .d(grad_x), .q(gx_d2));
  lsk_delay #(W, 2) u_gy_d2 (.clk, .en(en[2:1]), .d(grad_y), .q(gy_d2));
  lsk_delay #(W, 2) u_gz_d2 (.clk, .en(en[2:1]), .d(grad_z), .q(gz_d2));

  // stages 3-4: second level of products, gradient square sum
  lsk_mul #(W, FRAC_BITS) u_p4    (.clk, .en(en[4:3]), .a(p2),   .b(p2),    .y(p4));
  lsk_mul #(W, FRAC_BITS) u_qbp2  (.clk, .en(en[4:3]), .a(qb),   .b(p2),    .y(qbp2));
  lsk_mul #(W, FRAC_BITS) u_p2v   (.clk, .en(en[4:3]), .a(p2),   .b(v_d2),  .y(p2v));
  lsk_mul #(W, FRAC_BITS) u_hap2  (.clk, .en(en[4:3]), .a(ha),   .b(p2),    .y(hap2));
  lsk_mul #(W, FRAC_BITS) u_kvlap (.clk, .en(en[4:3]), .a(grad_penalty), .b(vlap), .y(kvlap));
  lsk_mul #(W, FRAC_BITS) u_sxx   (.clk, .en(en[4:3]), .a(kgx),  .b(gx_d2), .y(s_xx));
  lsk_mul #(W, FRAC_BITS) u_sxy   (.clk, .en(en[4:3]), .a(kgx),  .b(gy_d2), .y(s_xy));
  lsk_mul #(W, FRAC_BITS) u_sxz   (.clk, .en(en[4:3]), .a(kgx),  .b(gz_d2), .y(s_xz));
  lsk_mul #(W, FRAC_BITS) u_syy   (.clk, .en(en[4:3]), .a(kgy),  .b(gy_d2), .y(s_yy));
  lsk_mul #(W, FRAC_BITS) u_syz   (.clk, .en(en[4:3]), .a(kgy),  .b(gz_d2), .y(s_yz));
  lsk_mul #(W, FRAC_BITS) u_szz   (.clk, .en(en[4:3]), .a(kgz),  .b(gz_d2), .y(s_zz));

  lsk_addsub #(W, 1'b0) u_g01 (.clk, .en(en[3]), .a(gx2), .b(gy2),    .y(g01));
  lsk_delay  #(W, 1)    u_gz2_d3 (.clk, .en(en[3:3]), .d(gz2), .q(gz2_d3));
  lsk_addsub #(W, 1'b0) u_gg  (.clk, .en(en[4]), .a(g01), .b(gz2_d3), .y(gg));

  lsk_delay #(W, 2) u_ha_d4   (.clk, .en(en[4:3]), .d(ha),   .q(ha_d4));
  lsk_delay #(W, 3) u_hk_d5   (.clk, .en(en[5:3]), .d(hk),   .q(hk_d5));
  lsk_delay #(W, 3) u_tb_d5   (.clk, .en(en[5:3]), .d(tb),   .q(tb_d5));
  lsk_delay #(W, 3) u_p2_d5   (.clk, .en(en[5:3]), .d(p2),   .q(p2_d5));
  lsk_delay #(W, 5) u_av_d7   (.clk, .en(en[7:3]), .d(av),   .q(av_d7));
  lsk_delay #(W, 6) u_klap_d8 (.clk, .en(en[8:3]), .d(klap), .q(klap_d8));

  // stage 5: quadratic bracket of the energy
  lsk_addsub #(W, 1'b0) u_t (.clk, .en(en[5]), .a(ha_d4), .b(qbp2), .y(t_s5));

  lsk_delay #(W, 1) u_gg_d5    (.clk, .en(en[5:5]), .d(gg),    .q(gg_d5));
  lsk_delay #(W, 1) u_p4_d5    (.clk, .en(en[5:5]), .d(p4),    .q(p4_d5));
  lsk_delay #(W, 1) u_p2v_d5   (.clk, .en(en[5:5]), .d(p2v),   .q(p2v_d5));
  lsk_delay #(W, 3) u_hap2_d7  (.clk, .en(en[7:5]), .d(hap2),  .q(hap2_d7));
  lsk_delay #(W, 4) u_kvlap_d8 (.clk, .en(en[8:5]), .d(kvlap), .q(kvlap_d8));
  lsk_delay #(W, 6) u_sxx_d10  (.clk, .en(en[10:5]), .d(s_xx), .q(sxx));
  lsk_delay #(W, 6) u_sxy_d10  (.clk, .en(en[10:5]), .d(s_xy), .q(sxy));
  lsk_delay #(W, 6) u_sxz_d10  (.clk, .en(en[10:5]), .d(s_xz), .q(sxz));
  lsk_delay #(W, 6) u_syy_d10  (.clk, .en(en[10:5]), .d(s_yy), .q(syy));
  lsk_delay #(W, 6) u_syz_d10  (.clk, .en(en[10:5]), .d(s_yz), .q(syz));
  lsk_delay #(W, 6) u_szz_d10  (.clk, .en(en[10:5]), .d(s_zz), .q(szz));

  // stages 6-7: third level of products
  lsk_mul #(W, FRAC_BITS) u_tp2  (.clk, .en(en[7:6]), .a(t_s5),  .b(p2_d5),  .y(tp2));
  lsk_mul #(W, FRAC_BITS) u_tbp4 (.clk, .en(en[7:6]), .a(tb_d5), .b(p4_d5),  .y(tbp4));
  lsk_mul #(W, FRAC_BITS) u_bp2v (.clk, .en(en[7:6]), .a(quartic_coef), .b(p2v_d5), .y(bp2v));
  lsk_mul #(W, FRAC_BITS) u_hkgg (.clk, .en(en[7:6]), .a(hk_d5), .b(gg_d5),  .y(hkgg));

  // stage 8: first sums
  lsk_addsub #(W, 1'b0) u_fe (.clk, .en(en[8]), .a(tp2),     .b(hkgg), .y(fe_s8));
  lsk_addsub #(W, 1'b0) u_m1 (.clk, .en(en[8]), .a(av_d7),   .b(bp2v), .y(m1_s8));
  lsk_addsub #(W, 1'b0) u_pa (.clk, .en(en[8]), .a(hap2_d7), .b(tbp4), .y(pa_s8));
  lsk_delay  #(W, 2)    u_hkgg_d9 (.clk, .en(en[9:8]), .d(hkgg), .q(hkgg_d9));

  // stage 9: laplacian terms
  lsk_addsub #(W, 1'b1) u_mu (.clk, .en(en[9]), .a(m1_s8), .b(klap_d8),  .y(mu_s9));
  lsk_addsub #(W, 1'b1) u_pb (.clk, .en(en[9]), .a(pa_s8), .b(kvlap_d8), .y(pb_s9));
  lsk_delay  #(W, 2)    u_fe_d10 (.clk, .en(en[10:9]), .d(fe_s8), .q(energy));

  // stage 10: gradient term of the pressure
  lsk_addsub #(W, 1'b1) u_p0 (.clk, .en(en[10]), .a(pb_s9), .b(hkgg_d9), .y(pres));
  lsk_delay  #(W, 1)    u_mu_d10 (.clk, .en(en[10:10]), .d(mu_s9), .q(mu));

endmodule

/* src/two_field_landau_site_kernel_unit.sv */
// two_field_landau_site_kernel_unit: top level of the site kernel
// holds the coefficient registers, pipeline valid/stall control and the
// final sums; uses lsk_pkg, lsk_field, lsk_addsub, lsk_delay
//
// Usage:
//   The in_ channel takes one lattice site per word: both order parameters,
//   their gradients and Laplacians. The out_ channel returns one word per
//   site: energy density, two chemical potentials and the six stress
//   entries, all signed fixed point and saturated.
//   The six coefficients are written through cfg_we / cfg_index /
//   cfg_wdata while no site is in flight; an index above five is ignored.
//   The pipeline has 13 register stages: out_valid rises when an accepted
//   word reaches the last one. The stages are three levels of two-stage
//   multipliers plus saturating add stages. One word is taken per cycle as
//   long as the receiver keeps out_ready high.
//   When out_ready is low the last stage holds its word; earlier stages
//   keep moving into empty slots, so in_ready stays high until every
//   stage holds a word.
//   Synchronous reset empties the pipeline and clears the coefficients.
module two_field_landau_site_kernel_unit import lsk_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [DATA_WIDTH-1:0]        cfg_wdata,
  // site input
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_phi_value,
  input  logic signed [DATA_WIDTH-1:0] in_psi_value,
  input  logic signed [DATA_WIDTH-1:0] in_phi_grad_x,
  input  logic signed [DATA_WIDTH-1:0] in_phi_grad_y,
  input  logic signed [DATA_WIDTH-1:0] in_phi_grad_z,
  input  logic signed [DATA_WIDTH-1:0] in_psi_grad_x,
  input  logic signed [DATA_WIDTH-1:0] in_psi_grad_y,
  input  logic signed [DATA_WIDTH-1:0] in_psi_grad_z,
  input  logic signed [DATA_WIDTH-1:0] in_phi_laplacian,
  input  logic signed [DATA_WIDTH-1:0] in_psi_laplacian,
  // site result
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_energy_density,
  output logic signed [DATA_WIDTH-1:0] out_mu_phi_out,
  output logic signed [DATA_WIDTH-1:0] out_mu_psi_out,
  output logic signed [DATA_WIDTH-1:0] out_stress_xx,
  output logic signed [DATA_WIDTH-1:0] out_stress_xy,
  output logic signed [DATA_WIDTH-1:0] out_stress_xz,
  output logic signed [DATA_WIDTH-1:0] out_stress_yy,
  output logic signed [DATA_WIDTH-1:0] out_stress_yz,
  output logic signed [DATA_WIDTH-1:0] out_stress_zz
);

  localparam int W = DATA_WIDTH;

  logic signed [W-1:0] quad_coef_one_r, quartic_coef_one_r, grad_penalty_one_r;
  logic signed [W-1:0] quad_coef_two_r, quartic_coef_two_r, grad_penalty_two_r;

  logic [PIPE_STAGES:1] vld_r;
  logic [PIPE_STAGES:1] vld_nxt;
  logic [PIPE_STAGES:1] en;

  logic signed [W-1:0] fe1, mu1, p01, s1xx, s1xy, s1xz, s1yy, s1yz, s1zz;
  logic signed [W-1:0] fe2, mu2, p02, s2xx, s2xy, s2xz, s2yy, s2yz, s2zz;
  logic signed [W-1:0] fe_s11, p0_s11, oxy_s11, oxz_s11, oyz_s11;
  logic signed [W-1:0] s1xx_d11, s1yy_d11, s1zz_d11;
  logic signed [W-1:0] s2xx_d12, s2yy_d12, s2zz_d12;
  logic signed [W-1:0] dxx_s12, dyy_s12, dzz_s12;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quad_coef_one_r    <= '0;
      quartic_coef_one_r <= '0;
      grad_penalty_one_r <= '0;
      quad_coef_two_r    <= '0;
      quartic_coef_two_r <= '0;
      grad_penalty_two_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_QUAD_ONE:    quad_coef_one_r    <= cfg_wdata;
        REG_QUARTIC_ONE: quartic_coef_one_r <= cfg_wdata;
        REG_GRAD_ONE:    grad_penalty_one_r <= cfg_wdata;
        REG_QUAD_TWO:    quad_coef_two_r    <= cfg_wdata;
        REG_QUARTIC_TWO: quartic_coef_two_r <= cfg_wdata;
        REG_GRAD_TWO:    grad_penalty_two_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage enables: a stage loads when it is empty or its successor moves
  always_comb begin
    en[PIPE_STAGES] = !vld_r[PIPE_STAGES] || out_ready;
    for (int k = PIPE_STAGES - 1; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt = vld_r;
    if (en[1]) begin
      vld_nxt[1] = in_valid;
    end
    for (int k = 2; k <= PIPE_STAGES; k++) begin
      if (en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld_r[PIPE_STAGES];

  // per-field datapaths, stages 1-10
  lsk_field #(W, FRAC_BITS) u_field_phi (
    .clk, .en(en[FLD_STAGES:1]),
    .quad_coef(quad_coef_one_r), .quartic_coef(quartic_coef_one_r),
    .grad_penalty(grad_penalty_one_r),
    .value(in_phi_value), .grad_x(in_phi_grad_x), .grad_y(in_phi_grad_y),
    .grad_z(in_phi_grad_z), .laplacian(in_phi_laplacian),
    .energy(fe1), .mu(mu1), .pres(p01),
    .sxx(s1xx), .sxy(s1xy), .sxz(s1xz), .syy(s1yy), .syz(s1yz), .szz(s1zz)
  );

  lsk_field #(W, FRAC_BITS) u_field_psi (
    .clk, .en(en[FLD_STAGES:1]),
    .quad_coef(quad_coef_two_r), .quartic_coef(quartic_coef_two_r),
    .grad_penalty(grad_penalty_two_r),
    .value(in_psi_value), .grad_x(in_psi_grad_x), .grad_y(in_psi_grad_y),
    .grad_z(in_psi_grad_z), .laplacian(in_psi_laplacian),
    .energy(fe2), .mu(mu2), .pres(p02),
    .sxx(s2xx), .sxy(s2xy), .sxz(s2xz), .syy(s2yy), .syz(s2yz), .szz(s2zz)
  );

  // stage 11: field sums and off-diagonal stress
  lsk_addsub #(W, 1'b0) u_fe  (.clk, .en(en[11]), .a(fe1),  .b(fe2),  .y(fe_s11));
  lsk_addsub #(W, 1'b0) u_p0  (.clk, .en(en[11]), .a(p01),  .b(p02),  .y(p0_s11));
  lsk_addsub #(W, 1'b0) u_oxy (.clk, .en(en[11]), .a(s1xy), .b(s2xy), .y(oxy_s11));
  lsk_addsub #(W, 1'b0) u_oxz (.clk, .en(en[11]), .a(s1xz), .b(s2xz), .y(oxz_s11));
  lsk_addsub #(W, 1'b0) u_oyz (.clk, .en(en[11]), .a(s1yz), .b(s2yz), .y(oyz_s11));

  lsk_delay #(W, 3) u_mu1_d13 (.clk, .en(en[13:11]), .d(mu1), .q(out_mu_phi_out));
  lsk_delay #(W, 3) u_mu2_d13 (.clk, .en(en[13:11]), .d(mu2), .q(out_mu_psi_out));
  lsk_delay #(W, 1) u_s1xx_d11 (.clk, .en(en[11:11]), .d(s1xx), .q(s1xx_d11));
  lsk_delay #(W, 1) u_s1yy_d11 (.clk, .en(en[11:11]), .d(s1yy), .q(s1yy_d11));
  lsk_delay #(W, 1) u_s1zz_d11 (.clk, .en(en[11:11]), .d(s1zz), .q(s1zz_d11));
  lsk_delay #(W, 2) u_s2xx_d12 (.clk, .en(en[12:11]), .d(s2xx), .q(s2xx_d12));
  lsk_delay #(W, 2) u_s2yy_d12 (.clk, .en(en[12:11]), .d(s2yy), .q(s2yy_d12));
  lsk_delay #(W, 2) u_s2zz_d12 (.clk, .en(en[12:11]), .d(s2zz), .q(s2zz_d12));

  // stage 12: pressure plus first field on the diagonal
  lsk_addsub #(W, 1'b0) u_dxx (.clk, .en(en[12]), .a(p0_s11), .b(s1xx_d11), .y(dxx_s12));
  lsk_addsub #(W, 1'b0) u_dyy (.clk, .en(en[12]), .a(p0_s11), .b(s1yy_d11), .y(dyy_s12));
  lsk_addsub #(W, 1'b0) u_dzz (.clk, .en(en[12]), .a(p0_s11), .b(s1zz_d11), .y(dzz_s12));

  lsk_delay #(W, 2) u_fe_d13  (.clk, .en(en[13:12]), .d(fe_s11),  .q(out_energy_density));
  lsk_delay #(W, 2) u_oxy_d13 (.clk, .en(en[13:12]), .d(oxy_s11), .q(out_stress_xy));
  lsk_delay #(W, 2) u_oxz_d13 (.clk, .en(en[13:12]), .d(oxz_s11), .q(out_stress_xz));
  lsk_delay #(W, 2) u_oyz_d13 (.clk, .en(en[13:12]), .d(oyz_s11), .q(out_stress_yz));

  // stage 13: second field on the diagonal, output register
  lsk_addsub #(W, 1'b0) u_sxx (.clk, .en(en[13]), .a(dxx_s12), .b(s2xx_d12), .y(out_stress_xx));
  lsk_addsub #(W, 1'b0) u_syy (.clk, .en(en[13]), .a(dyy_s12), .b(s2yy_d12), .y(out_stress_yy));
  lsk_addsub #(W, 1'b0) u_szz (.clk, .en(en[13]), .a(dzz_s12), .b(s2zz_d12), .y(out_stress_zz));

  // input is refused only when every stage holds a word
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&vld_r))
    else $error("input stalled with an empty stage in the pipeline");

  // a word in the next-to-last stage reaches the output when it may move
  a_last_move: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[PIPE_STAGES-1] && en[PIPE_STAGES]) |=> out_valid)
    else $error("word lost between the last two stages");

  // a new result only appears from the stage before it
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(vld_r[PIPE_STAGES-1]))
    else $error("result appeared without a word behind it");

endmodule

/* dv/tb_top.sv */
// tb_top: self-checking bench for two_field_landau_site_kernel_unit
// drives random lattice sites and coefficient sets, checks every result word
// against a saturating Q8.24 model of the kernel; depends on lsk_pkg
`timescale 1ns / 1ps

module tb_top;
  import lsk_pkg::*;

  localparam int DW = DATA_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;

  // spare register indexes, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // fixed point constants and saturation bounds
  localparam longint Q_HALF    = 64'sd1 <<< (FB - 1);
  localparam longint Q_QUARTER = 64'sd1 <<< (FB - 2);
  localparam longint Q_THREEQ  = 64'sd3 <<< (FB - 2);
  localparam longint SAT_MAX   = (64'sd1 <<< (DW - 1)) - 1;
  localparam longint SAT_MIN   = -SAT_MAX - 1;

  localparam logic [DW-1:0] W_MAX     = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] W_MIN     = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] W_ONE     = DW'(64'sd1 <<< FB);
  localparam logic [DW-1:0] W_NEG_ONE = DW'(-(64'sd1 <<< FB));
  localparam logic [DW-1:0] W_HALF    = DW'(64'sd1 <<< (FB - 1));

  // site word: 0 phi, 1 psi, 2..4 phi grad xyz, 5..7 psi grad xyz,
  // 8 phi laplacian, 9 psi laplacian
  typedef logic [9:0][DW-1:0] site_in_t;
  // result word: 0 energy, 1 mu phi, 2 mu psi, 3..8 stress xx xy xz yy yz zz
  typedef logic [8:0][DW-1:0] site_out_t;

  function automatic string out_field_name(int i);
    case (i)
      0: return "energy_density";
      1: return "mu_phi_out";
      2: return "mu_psi_out";
      3: return "stress_xx";
      4: return "stress_xy";
      5: return "stress_xz";
      6: return "stress_yy";
      7: return "stress_yz";
      default: return "stress_zz";
    endcase
  endfunction

  // coefficient copy, kernel arithmetic and the queue of pending results
  class site_ledger;
    longint    coef[6];
    site_out_t pending_results[$];
    int        mismatches;
    int        shown;

    function new();
      for (int i = 0; i < 6; i++) coef[i] = 0;
      mismatches = 0;
      shown = 0;
    endfunction

    function void set_coef(logic [CFG_IDX_W-1:0] idx, logic [DW-1:0] val);
      if (idx <= REG_GRAD_TWO) coef[idx] = longint'($signed(val));
    endfunction

    function longint clampv(longint v);
      if (v > SAT_MAX) return SAT_MAX;
      if (v < SAT_MIN) return SAT_MIN;
      return v;
    endfunction

    function longint sat_add(longint a, longint b);
      return clampv(a + b);
    endfunction

    function longint sat_sub(longint a, longint b);
      return clampv(a - b);
    endfunction

    // exact product, round half up, then saturate
    function longint sat_mul(longint a, longint b);
      longint p;
      p = a * b + Q_HALF;
      return clampv(p >>> FB);
    endfunction

    // energy part, chemical potential and isotropic pressure of one field
    function void field_terms(input longint a, input longint b, input longint k,
                              input longint v, input longint g0, input longint g1,
                              input longint g2, input longint lap,
                              output longint fe, output longint mu,
                              output longint p0);
      longint p2, p4, gg, ha, hk, t;
      p2 = sat_mul(v, v);
      p4 = sat_mul(p2, p2);
      gg = sat_add(sat_add(sat_mul(g0, g0), sat_mul(g1, g1)), sat_mul(g2, g2));
      ha = sat_mul(Q_HALF, a);
      hk = sat_mul(Q_HALF, k);
      t  = sat_add(ha, sat_mul(sat_mul(Q_QUARTER, b), p2));
      fe = sat_add(sat_mul(t, p2), sat_mul(hk, gg));
      mu = sat_sub(sat_add(sat_mul(a, v), sat_mul(b, sat_mul(p2, v))), sat_mul(k, lap));
      t  = sat_add(sat_mul(ha, p2), sat_mul(sat_mul(Q_THREEQ, b), p4));
      t  = sat_sub(t, sat_mul(k, sat_mul(v, lap)));
      p0 = sat_sub(t, sat_mul(hk, gg));
    endfunction

    function site_out_t site_response(site_in_t s);
      longint    gp[3], gq[3];
      longint    fe1, mu1, p01, fe2, mu2, p02, p0, acc;
      int        ra, rb;
      site_out_t r;
      for (int i = 0; i < 3; i++) begin
        gp[i] = longint'($signed(s[2+i]));
        gq[i] = longint'($signed(s[5+i]));
      end
      field_terms(coef[REG_QUAD_ONE], coef[REG_QUARTIC_ONE], coef[REG_GRAD_ONE],
                  longint'($signed(s[0])), gp[0], gp[1], gp[2],
                  longint'($signed(s[8])), fe1, mu1, p01);
      field_terms(coef[REG_QUAD_TWO], coef[REG_QUARTIC_TWO], coef[REG_GRAD_TWO],
                  longint'($signed(s[1])), gq[0], gq[1], gq[2],
                  longint'($signed(s[9])), fe2, mu2, p02);
      p0 = sat_add(p01, p02);
      r[0] = DW'(sat_add(fe1, fe2));
      r[1] = DW'(mu1);
      r[2] = DW'(mu2);
      // stress entries in order xx xy xz yy yz zz
      for (int i = 0; i < 6; i++) begin
        case (i)
          0: begin ra = 0; rb = 0; end
          1: begin ra = 0; rb = 1; end
          2: begin ra = 0; rb = 2; end
          3: begin ra = 1; rb = 1; end
          4: begin ra = 1; rb = 2; end
          default: begin ra = 2; rb = 2; end
        endcase
        acc = (ra == rb) ? p0 : 0;
        acc = sat_add(acc, sat_mul(sat_mul(coef[REG_GRAD_ONE], gp[ra]), gp[rb]));
        acc = sat_add(acc, sat_mul(sat_mul(coef[REG_GRAD_TWO], gq[ra]), gq[rb]));
        r[3+i] = DW'(acc);
      end
      return r;
    endfunction

    function void note_site(site_in_t s);
      pending_results.push_back(site_response(s));
    endfunction

    function void check_site(site_out_t got);
      site_out_t want;
      bit        bad;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (shown < 10) begin
          shown++;
          $display("[%0t] result word with no site pending: energy %h", $realtime, got[0]);
        end
        return;
      end
      want = pending_results.pop_front();
      bad = 0;
      for (int i = 0; i < 9; i++) begin
        if (got[i] !== want[i]) begin
          bad = 1;
          if (shown < 10)
            $display("[%0t] %s mismatch: expected %h actual %h", $realtime,
                     out_field_name(i), want[i], got[i]);
        end
      end
      if (bad) begin
        mismatches++;
        if (shown < 10) shown++;
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DW-1:0]        cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  site_in_t             in_word;
  logic                 out_valid;
  logic                 out_ready;
  site_out_t            out_word;

  site_ledger ledger;
  int         gap_pct;
  int         stall_pct;

  two_field_landau_site_kernel_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_phi_value      (in_word[0]),
    .in_psi_value      (in_word[1]),
    .in_phi_grad_x     (in_word[2]),
    .in_phi_grad_y     (in_word[3]),
    .in_phi_grad_z     (in_word[4]),
    .in_psi_grad_x     (in_word[5]),
    .in_psi_grad_y     (in_word[6]),
    .in_psi_grad_z     (in_word[7]),
    .in_phi_laplacian  (in_word[8]),
    .in_psi_laplacian  (in_word[9]),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_energy_density(out_word[0]),
    .out_mu_phi_out    (out_word[1]),
    .out_mu_psi_out    (out_word[2]),
    .out_stress_xx     (out_word[3]),
    .out_stress_xy     (out_word[4]),
    .out_stress_xz     (out_word[5]),
    .out_stress_yy     (out_word[6]),
    .out_stress_yz     (out_word[7]),
    .out_stress_zz     (out_word[8])
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #8_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, 4);
    return $urandom_range(12, 40);
  endfunction

  // values spread over magnitudes so results are not always saturated
  function automatic logic [DW-1:0] rand_q();
    int r;
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2, 3, 4: r = int'($urandom_range(0, 1 << 26)) - (1 << 25);
      5, 6: r = int'($urandom_range(0, 1 << 24)) - (1 << 23);
      7: r = int'($urandom_range(0, 1 << 29)) - (1 << 28);
      8: begin
        case ($urandom_range(0, 6))
          0: return W_MAX;
          1: return W_MIN;
          2: return '0;
          3: return W_ONE;
          4: return W_NEG_ONE;
          5: return DW'(1);
          default: return '1;
        endcase
      end
      default: r = int'($urandom_range(0, 1 << 13)) - (1 << 12);
    endcase
    return DW'(r);
  endfunction

  function automatic site_in_t fill_site(logic [DW-1:0] v);
    site_in_t s;
    for (int i = 0; i < 10; i++) s[i] = v;
    return s;
  endfunction

  function automatic site_in_t rand_site();
    site_in_t s;
    for (int i = 0; i < 10; i++) s[i] = rand_q();
    return s;
  endfunction

  // result side: accept and check at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) ledger.check_site(out_word);
  end

  // receiver stalls
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < stall_pct) stall_left = pick_gap();
      end
    end
  end

  // one site word, with an optional idle gap in front
  task automatic send_site(site_in_t s);
    int gap;
    gap = ($urandom_range(0, 99) < gap_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_word  <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ledger.note_site(s);
  endtask

  // stop sending and wait until every result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (PIPE_STAGES + 2) @(posedge clk);
  endtask

  task automatic write_coef(logic [CFG_IDX_W-1:0] idx, logic [DW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    ledger.set_coef(idx, val);
  endtask

  // full coefficient set, written only with the pipeline empty
  task automatic load_coefs(logic [DW-1:0] a1, logic [DW-1:0] b1, logic [DW-1:0] k1,
                            logic [DW-1:0] a2, logic [DW-1:0] b2, logic [DW-1:0] k2);
    drain_results();
    write_coef(REG_QUAD_ONE, a1);
    write_coef(REG_QUARTIC_ONE, b1);
    write_coef(REG_GRAD_ONE, k1);
    write_coef(REG_QUAD_TWO, a2);
    write_coef(REG_QUARTIC_TWO, b2);
    write_coef(REG_GRAD_TWO, k2);
    // spare index must leave every coefficient alone
    write_coef($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
  endtask

  // main sequence
  initial begin
    site_in_t s;
    ledger    = new();
    gap_pct   = 30;
    stall_pct = 20;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_word   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // coefficients still zero after reset
    send_site(fill_site('0));
    send_site(fill_site(W_MAX));

    // moderate coefficients
    load_coefs(W_NEG_ONE, W_ONE, W_HALF, DW'(64'sd1 <<< (FB - 2)), DW'(-(64'sd1 <<< (FB - 1))),
               DW'(64'sd3 <<< (FB - 1)));
    send_site(fill_site(W_ONE));
    send_site(fill_site(W_NEG_ONE));
    send_site(fill_site(W_MAX));
    send_site(fill_site(W_MIN));
    s = fill_site({(DW/2){2'b01}});
    for (int i = 1; i < 10; i += 2) s[i] = {(DW/2){2'b10}};
    send_site(s);
    send_site(fill_site(DW'(1)));
    send_site(fill_site('1));
    // products landing exactly on a rounding tie
    s = fill_site(DW'(1 << 12));
    s[3] = DW'(1 << 11);
    s[4] = DW'(-(1 << 11));
    s[6] = DW'(-(1 << 12));
    send_site(s);
    // opposite extremes side by side
    s = fill_site(W_MAX);
    for (int i = 1; i < 10; i += 2) s[i] = W_MIN;
    send_site(s);

    // coefficient extremes
    load_coefs(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX);
    send_site(fill_site(W_ONE));
    send_site(fill_site(W_MIN));
    send_site(fill_site(W_MAX));
    load_coefs(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN);
    send_site(fill_site(W_NEG_ONE));
    send_site(fill_site(W_MAX));
    send_site(fill_site(W_HALF));
    load_coefs(W_MAX, W_MIN, W_MAX, W_MIN, W_MAX, W_MIN);
    send_site(fill_site(DW'(1 << 20)));
    send_site(fill_site(DW'(-(1 << 20))));

    // random sites under random coefficient sets
    for (int ph = 0; ph < 8; ph++) begin
      load_coefs(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
      case (ph)
        5: begin gap_pct = 0; stall_pct = 0; end
        6: begin gap_pct = 10; stall_pct = 60; end
        7: begin gap_pct = 60; stall_pct = 5; end
        default: begin
          gap_pct   = $urandom_range(5, 40);
          stall_pct = $urandom_range(5, 40);
        end
      endcase
      for (int n = 0; n < 166; n++) begin
        send_site(rand_site());
        if (ph == 3 && n == 80) drain_results();
      end
    end

    drain_results();
    if (ledger.mismatches == 0 && ledger.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
